// File: sv/ste_pkg.sv
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types and constants of the symmetric tour enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

package ste_pkg;

    localparam int NODE_W    = 4;  // width of one node index
    localparam int NC_W      = 5;  // width of the node_count register
    localparam int DATA_W    = 8;  // byte-padded tdata width on both streams
    localparam int MIN_NODES = 3;  // smallest graph that has a tour
    localparam logic [NC_W-1:0] NC_RESET = NC_W'(4);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIVOT,
        ST_SWAP,
        ST_SORT,
        ST_CHECK,
        ST_EMIT,
        ST_DONE
    } ste_state_t;

    // controller to datapath
    typedef struct packed {
        logic cfg_write;
        logic perm_init;
        logic pivot_latch;
        logic swap;
        logic skip_setup;
        logic sort_step;
        logic pos_clear;
        logic out_tour;
        logic out_done;
    } ste_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic too_few;
        logic has_pivot;
        logic sorted;
        logic reject;
        logic pos_last;
    } ste_sts_t;

endpackage

`default_nettype wire

// File: sv/ste_ctrl.sv
// ----------------------------------------------------------------------------
// ste_ctrl
// Sequencer: steps the permutation through pivot, swap, sort and skip passes
// and drives the handshakes of all three channels.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic             restart,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output ste_pkg::ste_cmd_t     cmd,
    input  wire ste_pkg::ste_sts_t sts
);
    import ste_pkg::*;

    ste_state_t state_reg, state_next;
    logic       started_reg, started_next;
    logic       exhausted_reg, exhausted_next;
    logic       after_skip_reg, after_skip_next;
    logic       m_tvalid_reg, m_tvalid_next;

    logic in_acc;
    logic cfg_acc;
    logic out_free;
    logic started_eff;
    logic exhausted_eff;

    assign in_acc        = s_tvalid && (state_reg == ST_IDLE);
    // a waiting request goes first
    assign cfg_acc       = cfg_valid && !s_tvalid && (state_reg == ST_IDLE);
    assign out_free      = !m_tvalid_reg || m_tready;
    assign started_eff   = started_reg && !restart;
    assign exhausted_eff = exhausted_reg && !restart;

    // next state
    always_comb begin
        state_next      = state_reg;
        started_next    = started_reg;
        exhausted_next  = exhausted_reg;
        after_skip_next = after_skip_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cfg_acc) begin
                    started_next   = 1'b0;
                    exhausted_next = 1'b0;
                end
                if (in_acc) begin
                    started_next   = started_eff;
                    exhausted_next = exhausted_eff;
                    if (sts.too_few || exhausted_eff) begin
                        state_next = ST_DONE;
                    end else if (!started_eff) begin
                        started_next = 1'b1;
                        state_next   = ST_CHECK;
                    end else begin
                        state_next = ST_PIVOT;
                    end
                end
            end
            ST_PIVOT: begin
                if (sts.has_pivot) begin
                    state_next = ST_SWAP;
                end else begin
                    exhausted_next = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_SWAP: begin
                after_skip_next = 1'b0;
                state_next      = ST_SORT;
            end
            ST_SORT: begin
                if (sts.sorted) begin
                    state_next = after_skip_reg ? ST_PIVOT : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.reject) begin
                    after_skip_next = 1'b1;
                    state_next      = ST_SORT;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && sts.pos_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd           = '0;
        cfg_ready     = 1'b0;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cfg_ready     = !s_tvalid;
                s_tready      = 1'b1;
                cmd.cfg_write = cfg_acc;
                cmd.perm_init = cfg_acc || (in_acc && restart);
            end
            ST_PIVOT: begin
                cmd.pivot_latch = 1'b1;
            end
            ST_SWAP: begin
                cmd.swap = 1'b1;
            end
            ST_SORT: begin
                cmd.sort_step = !sts.sorted;
            end
            ST_CHECK: begin
                cmd.skip_setup = sts.reject;
                cmd.pos_clear  = !sts.reject;
            end
            ST_EMIT: begin
                cmd.out_tour = out_free;
            end
            ST_DONE: begin
                cmd.out_done = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_tour || cmd.out_done) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            started_reg    <= 1'b0;
            exhausted_reg  <= 1'b0;
            after_skip_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            started_reg    <= started_next;
            exhausted_reg  <= exhausted_next;
            after_skip_reg <= after_skip_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// File: sv/ste_datapath.sv
// ----------------------------------------------------------------------------
// ste_datapath
// Permutation register lanes with pivot, swap, odd-even sort and skip logic,
// the node_count register and the result payload registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_datapath #(
    parameter int MAX_NODES = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire ste_pkg::ste_cmd_t       cmd,
    input  wire logic [ste_pkg::NC_W-1:0] cfg_data,
    output ste_pkg::ste_sts_t            sts,
    output logic [ste_pkg::NODE_W-1:0]   node,
    output logic                         last,
    output logic                         done_res
);
    import ste_pkg::*;

    localparam int PERM_LEN = MAX_NODES - 1;
    localparam int IDX_W    = $clog2(MAX_NODES);
    localparam int CNT_W    = $clog2(MAX_NODES + 1);

    logic [NC_W-1:0]   node_count_reg;
    logic [NODE_W-1:0] perm_reg  [PERM_LEN];
    logic [NODE_W-1:0] perm_next [PERM_LEN];
    logic [NODE_W-1:0] sort_perm [PERM_LEN];
    logic [IDX_W-1:0]  piv_idx_reg;
    logic [NODE_W-1:0] piv_val_reg;
    logic [IDX_W-1:0]  lo_reg;
    logic              desc_reg;
    logic              phase_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [NODE_W-1:0] node_reg;
    logic              last_reg;
    logic              done_reg;

    logic [NC_W-1:0]     n_eff;
    logic [IDX_W-1:0]    hi_idx;
    logic                has_piv;
    logic [IDX_W-1:0]    piv_idx;
    logic [IDX_W-1:0]    k_idx;
    logic [NODE_W-1:0]   k_val;
    logic [IDX_W-1:0]    keep_idx;
    logic [PERM_LEN-2:0] bad;
    logic [PERM_LEN-2:0] swp;
    logic [IDX_W-1:0]    pos_idx;
    logic                pos_last;

    assign n_eff   = (node_count_reg > NC_W'(MAX_NODES)) ? NC_W'(MAX_NODES) : node_count_reg;
    assign hi_idx  = IDX_W'(n_eff - NC_W'(2));
    assign pos_idx = IDX_W'(pos_reg - CNT_W'(1));
    assign pos_last = (pos_reg == CNT_W'(n_eff - NC_W'(1)));

    // rightmost ascent
    always_comb begin
        has_piv = 1'b0;
        piv_idx = '0;
        for (int x = 0; x < PERM_LEN - 1; x++) begin
            if (IDX_W'(x) < hi_idx && perm_reg[x] < perm_reg[x+1]) begin
                has_piv = 1'b1;
                piv_idx = IDX_W'(x);
            end
        end
    end

    // rightmost element above the pivot value
    always_comb begin
        k_idx = '0;
        for (int x = 0; x < PERM_LEN; x++) begin
            if (IDX_W'(x) > piv_idx_reg && IDX_W'(x) <= hi_idx &&
                perm_reg[x] > piv_val_reg) begin
                k_idx = IDX_W'(x);
            end
        end
    end
    assign k_val = perm_reg[k_idx];

    // last place not below the head: everything after it goes descending
    always_comb begin
        keep_idx = '0;
        for (int x = 0; x < PERM_LEN; x++) begin
            if (IDX_W'(x) < hi_idx && perm_reg[x] >= perm_reg[0]) begin
                keep_idx = IDX_W'(x);
            end
        end
    end

    // odd-even transposition over [lo_reg, hi_idx]
    always_comb begin
        for (int x = 0; x < PERM_LEN - 1; x++) begin
            bad[x] = (IDX_W'(x) >= lo_reg) && (IDX_W'(x + 1) <= hi_idx) &&
                     (desc_reg ? (perm_reg[x] < perm_reg[x+1])
                               : (perm_reg[x] > perm_reg[x+1]));
            swp[x] = bad[x] && (1'(x) == phase_reg);
        end
        for (int x = 0; x < PERM_LEN; x++) begin
            sort_perm[x] = perm_reg[x];
        end
        for (int x = 0; x < PERM_LEN - 1; x++) begin
            if (swp[x]) begin
                sort_perm[x]     = perm_reg[x+1];
                sort_perm[x + 1] = perm_reg[x];
            end
        end
    end

    always_comb begin
        for (int x = 0; x < PERM_LEN; x++) begin
            if (cmd.perm_init) begin
                perm_next[x] = NODE_W'(x + 1);
            end else if (cmd.swap) begin
                if (IDX_W'(x) == piv_idx_reg) begin
                    perm_next[x] = k_val;
                end else if (IDX_W'(x) == k_idx) begin
                    perm_next[x] = piv_val_reg;
                end else begin
                    perm_next[x] = perm_reg[x];
                end
            end else if (cmd.sort_step) begin
                perm_next[x] = sort_perm[x];
            end else begin
                perm_next[x] = perm_reg[x];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NC_RESET;
            phase_reg      <= 1'b0;
            pos_reg        <= '0;
            for (int x = 0; x < PERM_LEN; x++) begin
                perm_reg[x] <= NODE_W'(x + 1);
            end
        end else begin
            if (cmd.cfg_write) begin
                node_count_reg <= cfg_data;
            end
            for (int x = 0; x < PERM_LEN; x++) begin
                perm_reg[x] <= perm_next[x];
            end
            if (cmd.sort_step) begin
                phase_reg <= ~phase_reg;
            end
            if (cmd.pos_clear) begin
                pos_reg <= '0;
            end else if (cmd.out_tour) begin
                pos_reg <= pos_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pivot_latch) begin
            piv_idx_reg <= piv_idx;
            piv_val_reg <= perm_reg[piv_idx];
        end
        if (cmd.swap) begin
            lo_reg   <= piv_idx_reg + IDX_W'(1);
            desc_reg <= 1'b0;
        end else if (cmd.skip_setup) begin
            lo_reg   <= keep_idx + IDX_W'(1);
            desc_reg <= 1'b1;
        end
        if (cmd.out_tour) begin
            node_reg <= (pos_reg == '0) ? '0 : perm_reg[pos_idx];
            last_reg <= pos_last;
            done_reg <= 1'b0;
        end else if (cmd.out_done) begin
            node_reg <= '0;
            last_reg <= 1'b1;
            done_reg <= 1'b1;
        end
    end

    assign sts.too_few   = (n_eff < NC_W'(MIN_NODES));
    assign sts.has_pivot = has_piv;
    assign sts.sorted    = ~|bad;
    assign sts.reject    = (perm_reg[0] > perm_reg[hi_idx]);
    assign sts.pos_last  = pos_last;

    assign node     = node_reg;
    assign last     = last_reg;
    assign done_res = done_reg;

endmodule

`default_nettype wire

// File: sv/symmetric_tour_enumerator_core.sv
// ----------------------------------------------------------------------------
// symmetric_tour_enumerator_core
// Lists the distinct tours of a complete symmetric graph, one per request.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : writes node_count (5 bits); also restarts the enumeration.
//            Taken only while the block is idle and no request is offered.
//   s_*    : one request per tour; s_tdata[0] = restart.
//   m_*    : n results per tour (node 0 first), m_tlast on the final node;
//            m_tuser = done flag, then a single result with node 0, tlast 1.
// Sequence: a tour runs pivot, swap, the ascending sort steps after the swap
//   and a check before its results; the first tour after a restart goes
//   straight to the check; each run of rejected arrangements adds a
//   descending sort and another advance; a done result is one output beat.
// Reset: node_count = 4, arrangement = identity, nothing started.
// Stalls: results sit in one output register; the sequencer waits while it
//   is full and m_tready is low. The next request is taken once the last
//   result of the current one is in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module symmetric_tour_enumerator_core #(
    parameter int MAX_NODES = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [ste_pkg::NC_W-1:0]   cfg_data,    // node_count
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [ste_pkg::DATA_W-1:0] s_tdata,     // [0] restart
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [ste_pkg::DATA_W-1:0]     m_tdata,     // [3:0] node
    output logic                           m_tlast,
    output logic                           m_tuser      // [0] done_res
);
    import ste_pkg::*;

    ste_cmd_t          cmd;
    ste_sts_t          sts;
    logic [NODE_W-1:0] node;

    ste_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .restart   (s_tdata[0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ste_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cfg_data  (cfg_data),
        .sts       (sts),
        .node      (node),
        .last      (m_tlast),
        .done_res  (m_tuser)
    );

    assign m_tdata = {{(DATA_W - NODE_W){1'b0}}, node};

endmodule

`default_nettype wire

// File: sv/ste_checker.sv
// ----------------------------------------------------------------------------
// ste_checker
// Port-level checks of the tour enumerator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ste_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       cfg_valid,
    input wire logic                       cfg_ready,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [ste_pkg::DATA_W-1:0] m_tdata,
    input wire logic                       m_tlast,
    input wire logic                       m_tuser
);

    // a done result is a single, last result carrying node 0
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("done result without tlast or with nonzero node");

    // one request at a time
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous one in progress");

    // configuration only taken while idle
    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |-> s_tready)
        else $error("configuration taken while busy");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind symmetric_tour_enumerator_core ste_checker u_ste_checker (.*);

`default_nettype wire

// File: verif/ste_tour_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_tour_checker
// Watches the configuration, request and result channels of the tour
// enumerator, keeps its own copy of the arrangement state, works out the tour
// (or done result) that each accepted request must produce and compares every
// accepted result with the oldest one still due.
// ----------------------------------------------------------------------------
module ste_tour_checker #(
    parameter int MAX_NODES = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    input  wire logic                       cfg_ready,
    input  wire logic [ste_pkg::NC_W-1:0]   cfg_data,
    input  wire logic                       s_tvalid,
    input  wire logic                       s_tready,
    input  wire logic [ste_pkg::DATA_W-1:0] s_tdata,    // [0] restart
    input  wire logic                       m_tvalid,
    input  wire logic                       m_tready,
    input  wire logic [ste_pkg::DATA_W-1:0] m_tdata,    // [3:0] node
    input  wire logic                       m_tlast,
    input  wire logic                       m_tuser,    // [0] done_res
    output int                              fail_count,
    output int                              pending,
    output int                              tours_seen,
    output int                              done_seen
);
    import ste_pkg::*;

    localparam int SLOTS = MAX_NODES - 1;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              last;
        logic              done;
    } tour_beat_t;

    logic [NC_W-1:0]   node_count_q;
    logic [NODE_W-1:0] order [SLOTS];
    bit                begun;
    bit                spent;
    tour_beat_t        beats_due [$];

    function automatic void queue_beat(tour_beat_t b);
        beats_due.insert(beats_due.size(), b);
    endfunction

    function automatic void rewind_order();
        for (int k = 0; k < SLOTS; k++) begin
            order[k] = NODE_W'(k + 1);
        end
        begun = 1'b0;
        spent = 1'b0;
    endfunction

    function automatic void flip_span(int lo, int hi);
        logic [NODE_W-1:0] t;
        while (lo < hi) begin
            t         = order[lo];
            order[lo] = order[hi];
            order[hi] = t;
            lo++;
            hi--;
        end
    endfunction

    // next arrangement of the first m slots; 0 when it wraps to the first one
    function automatic bit step_order(int m);
        int                i;
        int                k;
        logic [NODE_W-1:0] t;
        i = m - 2;
        while (i >= 0 && order[i] >= order[i + 1]) i--;
        if (i < 0) begin
            flip_span(0, m - 1);
            return 1'b0;
        end
        k = m - 1;
        while (order[k] <= order[i]) k--;
        t        = order[i];
        order[i] = order[k];
        order[k] = t;
        flip_span(i + 1, m - 1);
        return 1'b1;
    endfunction

    // all arrangements with this head and a smaller tail end get rejected:
    // move to the last of them so the next step leaves the run
    function automatic void jump_past_rejects(int m);
        logic [NODE_W-1:0] head;
        logic [NODE_W-1:0] v;
        int                j;
        int                b;
        head = order[0];
        j    = m - 1;
        while (j > 1 && order[j - 1] < head) j--;
        for (int a = j + 1; a < m; a++) begin
            v = order[a];
            b = a;
            while (b > j && order[b - 1] < v) begin
                order[b] = order[b - 1];
                b--;
            end
            order[b] = v;
        end
    endfunction

    function automatic void predict_tour(logic restart);
        int n;
        int m;
        bit found;
        n     = (node_count_q > MAX_NODES) ? MAX_NODES : int'(node_count_q);
        m     = n - 1;
        found = 1'b0;
        if (restart) rewind_order();
        if (n >= MIN_NODES && !spent) begin
            found = 1'b1;
            if (begun) found = step_order(m);
            begun = 1'b1;
            // reversed copies: first node above last node
            while (found && order[0] > order[m - 1]) begin
                jump_past_rejects(m);
                found = step_order(m);
            end
            spent = !found;
        end
        if (!found) begin
            queue_beat(tour_beat_t'({NODE_W'(0), 1'b1, 1'b1}));
        end else begin
            queue_beat(tour_beat_t'({NODE_W'(0), 1'b0, 1'b0}));
            for (int k = 0; k < m; k++) begin
                queue_beat(tour_beat_t'({order[k], k == m - 1, 1'b0}));
            end
        end
    endfunction

    always @(posedge aclk) begin : watch
        tour_beat_t got;
        tour_beat_t want;
        if (!aresetn) begin
            node_count_q = NC_RESET;
            rewind_order();
            beats_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = tour_beat_t'({m_tdata[NODE_W-1:0], m_tlast, m_tuser});
                if (got.done) done_seen++;
                else if (got.last) tours_seen++;
                if (beats_due.size() == 0) begin
                    $display("%0t: unexpected result node %0d last %0b done %0b",
                             $time, got.node, got.last, got.done);
                    fail_count++;
                end else begin
                    want = beats_due.pop_front();
                    if (got.node !== want.node || got.last !== want.last ||
                        got.done !== want.done) begin
                        $display("%0t: result mismatch: expected node %0d last %0b done %0b,",
                                 $time, want.node, want.last, want.done);
                        $display("    got node %0d last %0b done %0b",
                                 got.node, got.last, got.done);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                node_count_q = cfg_data;
                rewind_order();
            end
            if (s_tvalid && s_tready) predict_tour(s_tdata[0]);
        end
        pending = beats_due.size();
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives tour requests and node_count writes into the enumerator in random
// bursts while the result side stalls in its own pattern; the checker next
// to the block predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import ste_pkg::*;

    localparam int MAX_NODES     = 16;
    localparam int RANDOM_ITEMS  = 130;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 20000;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [NC_W-1:0]   cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata   = '0;    // [0] restart
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DATA_W-1:0] m_tdata;           // [3:0] node
    logic              m_tlast;
    logic              m_tuser;           // [0] done_res
    logic [7:0]        stall_phase = '0;

    int fail_count;
    int pending;
    int tours_seen;
    int done_seen;
    int requests_sent;
    int cfg_writes;
    int quiet_cycles;

    symmetric_tour_enumerator_core #(
        .MAX_NODES (MAX_NODES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    ste_tour_checker #(
        .MAX_NODES (MAX_NODES)
    ) i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .tours_seen (tours_seen),
        .done_seen  (done_seen)
    );

    always #1 aclk = ~aclk;

    // free-running counter picks the receiver mood: open, light, heavy, periodic
    always @(negedge aclk) begin
        stall_phase <= stall_phase + 8'd1;
        case (stall_phase[7:6])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_phase[2:0] == 3'd7);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no channel moved for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic restart);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(restart);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge aclk) s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // hold requests until every due result is out, then give the block time
    task automatic settle();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_node_count(input logic [NC_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk) cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        int              random_sent;
        int              phase_left;
        int              burst;
        int              gap;
        int              pick;
        logic [NC_W-1:0] nc;

        random_sent = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // reset count of four: three tours, then done until restart
        repeat (5) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        // three nodes: one tour, then done; restart brings it back
        write_node_count(NC_W'(3));
        repeat (3) send_request(1'b0);
        send_request(1'b1);
        // too few nodes
        write_node_count('0);
        send_request(1'b0);
        send_request(1'b1);
        write_node_count(NC_W'(2));
        send_request(1'b0);
        // above the maximum, used as the maximum
        write_node_count('1);
        repeat (2) send_request(1'b0);
        send_request(1'b1);
        write_node_count(NC_W'(MAX_NODES));
        send_request(1'b0);

        // mostly small graphs so enumerations run out, rare restarts
        while (random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)      nc = NC_W'($urandom_range(0, 2));
            else if (pick < 70) nc = NC_W'($urandom_range(3, 6));
            else if (pick < 90) nc = NC_W'($urandom_range(7, MAX_NODES));
            else                nc = NC_W'($urandom_range(MAX_NODES + 1, 31));
            write_node_count(nc);
            phase_left = $urandom_range(3, 18);
            while (phase_left > 0) begin
                burst = $urandom_range(1, 8);
                while (burst > 0 && phase_left > 0) begin
                    send_request($urandom_range(0, 11) == 0);
                    burst--;
                    phase_left--;
                    random_sent++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if ($urandom_range(0, 9) == 0) settle();
                else if (gap != 0) pause_sender(gap);
            end
        end

        settle();
        $display("covered %0d requests over %0d node_count writes", requests_sent, cfg_writes);
        $display("checked %0d tours and %0d done results", tours_seen, done_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
sv/ste_pkg.sv
sv/ste_ctrl.sv
sv/ste_datapath.sv
sv/symmetric_tour_enumerator_core.sv
sv/ste_checker.sv
verif/ste_tour_checker.sv
verif/tb.sv
